// File: rtl/java_int_divide_shift_unit_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the integer divide and shift unit
// compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef JAVA_INT_DIVIDE_SHIFT_UNIT_CORE_MACROS_SVH
`define JAVA_INT_DIVIDE_SHIFT_UNIT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define JIDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JIDS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define JIDS_ASSERT(label, clk, rst_n, prop, msg)
`define JIDS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/jids_pkg.sv
// ----------------------------------------------------------------------------
// jids_pkg
// types and constants shared by the divide and shift unit
// ----------------------------------------------------------------------------
package jids_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned StageN = 64;
  localparam int unsigned CntW   = 6;
  localparam int unsigned OpW    = 3;

  typedef enum logic [OpW-1:0] {
    OP_DIV32 = 3'd0,
    OP_REM32 = 3'd1,
    OP_DIV64 = 3'd2,
    OP_REM64 = 3'd3,
    OP_SHL64 = 3'd4,
    OP_SAR64 = 3'd5,
    OP_SHR64 = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [CntW-1:0]  shift_count;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             divide_by_zero;
  } out_item_t;

  // control carried beside the divider data
  typedef struct packed {
    logic             valid;
    logic             want_rem;
    logic             is32;
    logic             neg_q;
    logic             neg_r;
    logic             div_zero;
    logic             bypass;
    logic [DataW-1:0] bypass_val;
  } div_ctl_t;

endpackage

// File: rtl/java_int_divide_shift_unit_core.sv
// ----------------------------------------------------------------------------
// java_int_divide_shift_unit_core
// out_valid and the result are registered through the input stage, the
// divider step chain and the result stage, for every operation.
// Throughput: one transaction per cycle; busy is always low.
// Pipeline is 1 input stage, 64 restoring-divide stages, 1 result stage.
// Synchronous active-low reset clears all valid bits; output is unstallable.
// ----------------------------------------------------------------------------
`include "java_int_divide_shift_unit_core_macros.svh"
module java_int_divide_shift_unit_core
  import jids_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned LastSt = StageN;

  div_ctl_t         ctl [0:StageN];
  logic [DataW-1:0] rem [0:StageN];
  logic [DataW-1:0] quo [0:StageN];
  logic [DataW-1:0] dvs [0:StageN];

  logic [DataW-1:0] a_ext, b_ext, a_mag, b_mag, a_neg;
  logic             is32, is_div, want_rem, b_zero, b_m1;
  logic [DataW-1:0] shift_res;
  logic [DataW-1:0] sh_line_r [0:StageN-1];
  logic [DataW-1:0] q_fix, r_fix, fin_nxt;
  out_item_t        out_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  div_ctl_t         ctl0_nxt;
  div_ctl_t         ctl0_r;
  logic [DataW-1:0] a_mag_r, b_mag_r;
  op_t              op;

  assign busy = 1'b0;
  assign op   = op_t'(in_item.operation);

  // operand decode and sign handling
  always_comb begin
    is32     = (op == OP_DIV32) || (op == OP_REM32);
    is_div   = is32 || (op == OP_DIV64) || (op == OP_REM64);
    want_rem = (op == OP_REM32) || (op == OP_REM64);
    a_ext = is32 ? {{32{in_item.operand_a[31]}}, in_item.operand_a[31:0]}
                 : in_item.operand_a;
    b_ext = is32 ? {{32{in_item.operand_b[31]}}, in_item.operand_b[31:0]}
                 : in_item.operand_b;
    a_neg  = '0 - a_ext;
    a_mag  = a_ext[DataW-1] ? a_neg : a_ext;
    b_mag  = b_ext[DataW-1] ? ('0 - b_ext) : b_ext;
    b_zero = (b_ext == '0);
    b_m1   = (b_ext == '1);
    ctl0_nxt.valid      = start;
    ctl0_nxt.want_rem   = want_rem;
    ctl0_nxt.is32       = is32;
    ctl0_nxt.neg_q      = a_ext[DataW-1] ^ b_ext[DataW-1];
    ctl0_nxt.neg_r      = a_ext[DataW-1];
    ctl0_nxt.div_zero   = is_div && b_zero;
    ctl0_nxt.bypass     = !is_div || b_zero || b_m1;
    ctl0_nxt.bypass_val = (is_div && b_m1 && !want_rem) ? a_neg : '0;
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
    end else begin
      ctl0_r.valid <= ctl0_nxt.valid;
    end
    ctl0_r.want_rem   <= ctl0_nxt.want_rem;
    ctl0_r.is32       <= ctl0_nxt.is32;
    ctl0_r.neg_q      <= ctl0_nxt.neg_q;
    ctl0_r.neg_r      <= ctl0_nxt.neg_r;
    ctl0_r.div_zero   <= ctl0_nxt.div_zero;
    ctl0_r.bypass     <= ctl0_nxt.bypass;
    ctl0_r.bypass_val <= ctl0_nxt.bypass_val;
    a_mag_r <= a_mag;
    b_mag_r <= b_mag;
  end

  assign ctl[0] = ctl0_r;
  assign rem[0] = '0;
  assign quo[0] = a_mag_r;
  assign dvs[0] = b_mag_r;

  // shift result computed at entry, then held in a delay line
  jids_shift u_shift (
    .clk   (clk),
    .op    (in_item.operation),
    .val   (in_item.operand_a),
    .cnt   (in_item.shift_count),
    .res_r (shift_res)
  );

  // divider step chain
  for (genvar g = 0; g < StageN; g++) begin : g_st
    jids_div_stage u_st (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl[g]),
      .rem_i (rem[g]),
      .quo_i (quo[g]),
      .dvs_i (dvs[g]),
      .ctl_r (ctl[g+1]),
      .rem_r (rem[g+1]),
      .quo_r (quo[g+1]),
      .dvs_r (dvs[g+1])
    );
  end

  // shift values ride a delay line beside the divider chain
  always_ff @(posedge clk) begin
    sh_line_r[0] <= shift_res;
    for (int i = 1; i < StageN; i++) begin
      sh_line_r[i] <= sh_line_r[i-1];
    end
  end

  // sign fix and result select
  always_comb begin
    q_fix = ctl[LastSt].neg_q ? ('0 - quo[LastSt]) : quo[LastSt];
    r_fix = ctl[LastSt].neg_r ? ('0 - rem[LastSt]) : rem[LastSt];
    if (ctl[LastSt].bypass) begin
      fin_nxt = ctl[LastSt].bypass_val | sh_line_r[StageN-1];
    end else begin
      fin_nxt = ctl[LastSt].want_rem ? r_fix : q_fix;
    end
    if (ctl[LastSt].is32) begin
      fin_nxt = {{32{fin_nxt[31]}}, fin_nxt[31:0]};
    end
    out_nxt.result         = fin_nxt;
    out_nxt.divide_by_zero = ctl[LastSt].div_zero;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[LastSt].valid;
    end
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `JIDS_ASSERT(a_busy_low, clk, rst_n, (busy == 1'b0), "busy must stay low")
  `JIDS_ASSERT_NEXT(a_zero_res, clk, rst_n, ctl[LastSt].valid && ctl[LastSt].div_zero, out_valid && out_item.result == '0, "divide by zero result not zero")
  `JIDS_ASSERT(a_zero_op, clk, rst_n, !(ctl[LastSt].valid && ctl[LastSt].div_zero && !ctl[LastSt].bypass), "zero divisor not bypassed")

endmodule

// File: rtl/jids_shift.sv
// ----------------------------------------------------------------------------
// jids_shift
// registered 64-bit barrel shifter, one transaction per cycle
// ----------------------------------------------------------------------------
module jids_shift
  import jids_pkg::*;
(
  input  logic             clk,
  input  logic [OpW-1:0]   op,
  input  logic [DataW-1:0] val,
  input  logic [CntW-1:0]  cnt,
  output logic [DataW-1:0] res_r
);

  logic [DataW-1:0] res_nxt;
  logic [DataW-1:0] inv;

  // arithmetic right shift via inverted logical shift
  always_comb begin
    inv = ~val;
    case (op)
      OP_SHL64: res_nxt = val << cnt;
      OP_SAR64: res_nxt = val[DataW-1] ? ~(inv >> cnt) : (val >> cnt);
      OP_SHR64: res_nxt = val >> cnt;
      default:  res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: rtl/jids_div_stage.sv
// ----------------------------------------------------------------------------
// jids_div_stage
// one restoring-division step on magnitudes, registered
// ----------------------------------------------------------------------------
module jids_div_stage
  import jids_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl_i,
  input  logic [DataW-1:0] rem_i,
  input  logic [DataW-1:0] quo_i,
  input  logic [DataW-1:0] dvs_i,
  output div_ctl_t         ctl_r,
  output logic [DataW-1:0] rem_r,
  output logic [DataW-1:0] quo_r,
  output logic [DataW-1:0] dvs_r
);

  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic [DataW-1:0] rem_nxt;
  logic [DataW-1:0] quo_nxt;

  // shift in next dividend bit, try subtract
  always_comb begin
    trial   = {rem_i, quo_i[DataW-1]};
    diff    = trial - {1'b0, dvs_i};
    quo_nxt = {quo_i[DataW-2:0], ~diff[DataW]};
    rem_nxt = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.want_rem   <= ctl_i.want_rem;
    ctl_r.is32       <= ctl_i.is32;
    ctl_r.neg_q      <= ctl_i.neg_q;
    ctl_r.neg_r      <= ctl_i.neg_r;
    ctl_r.div_zero   <= ctl_i.div_zero;
    ctl_r.bypass     <= ctl_i.bypass;
    ctl_r.bypass_val <= ctl_i.bypass_val;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_i;
  end

endmodule
